>>> hdl/sfwa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed feedback window average: shared package
// Widths, constants and the command/status types that join the controller
// and the datapath.
// ----------------------------------------------------------------------------
package sfwa_pkg;

   localparam int WINDOW_LENGTH   = 20;
   localparam int SAMPLE_WIDTH    = 16;
   localparam int DEAD_BAND_WIDTH = 8;
   localparam logic [DEAD_BAND_WIDTH-1:0] DEAD_BAND_RESET = 8'd5;

   // Magnitude of a sample, wide enough for the most negative value.
   localparam int MAG_WIDTH   = SAMPLE_WIDTH + 1;
   // Index into the window scan.
   localparam int IDX_WIDTH   = $clog2(WINDOW_LENGTH);
   // Number of qualifying samples, 0 .. WINDOW_LENGTH.
   localparam int CNT_WIDTH   = $clog2(WINDOW_LENGTH + 1);
   // Signed running total over the whole window.
   localparam int SUM_WIDTH   = SAMPLE_WIDTH + $clog2(WINDOW_LENGTH);
   // One divider step per dividend bit.
   localparam int DIV_WIDTH   = $clog2(SUM_WIDTH);

   typedef struct packed {
      logic load;        // take a new beat into the window
      logic accumulate;  // rotate the window by one and add the tail entry if it passes the dead band
      logic div_start;   // set up the divider from the total and count
      logic div_step;    // one restoring division step
      logic finish;      // write the result into the output register
   } cmd_type;

   typedef struct packed {
      logic clear_needed; // incoming beat forces a window clear
      logic scan_last;    // last entry of the window scan
      logic count_zero;   // no sample passed the dead band
      logic div_last;     // last division step
      logic out_free;     // output register can take a result
   } status_type;

endpackage

>>> hdl/sfwa_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed feedback window average: controller
// Sequences the window scan, the serial divide and the result write.
// ----------------------------------------------------------------------------
module sfwa_controller
   import sfwa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_PREP = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.clear_needed ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.accumulate = 1'b1;
            if (status.scan_last) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (status.count_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // An accepted beat always starts a scan or goes straight to the result.
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN || state_ff == ST_DONE))
      else $error("accepted beat did not start processing");

   // A finished result waits while the output register is still occupied.
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !status.out_free) |=> state_ff == ST_DONE)
      else $error("result dropped while output busy");

endmodule

>>> hdl/sfwa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed feedback window average: datapath
// Sample window, dead band filter and accumulator, serial divider and
// output register.
// ----------------------------------------------------------------------------
module sfwa_datapath
   import sfwa_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output status_type                    status,
   input  logic signed [SAMPLE_WIDTH-1:0] req_velocity_sample,
   input  logic                          req_motion_lock,
   input  logic                          csr_write_enable,
   input  logic [DEAD_BAND_WIDTH-1:0]    csr_write_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_filtered_velocity
);

   logic signed [SAMPLE_WIDTH-1:0] window_ff [WINDOW_LENGTH];
   logic [DEAD_BAND_WIDTH-1:0]     dead_band_ff;
   logic [IDX_WIDTH-1:0]           scan_ff;
   logic signed [SUM_WIDTH-1:0]    sum_ff;
   logic [CNT_WIDTH-1:0]           count_ff;
   logic [SUM_WIDTH-1:0]           quo_ff;
   logic [CNT_WIDTH-1:0]           rem_ff;
   logic [DIV_WIDTH-1:0]           step_ff;
   logic                           negative_ff;
   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] result_ff;

   logic signed [SAMPLE_WIDTH-1:0] tail;
   logic [MAG_WIDTH-1:0]           tail_mag;
   logic                           tail_hit;
   logic [SUM_WIDTH-1:0]           sum_mag;
   logic [CNT_WIDTH:0]             rem_shift;
   logic [CNT_WIDTH:0]             rem_diff;
   logic                           rem_ge;
   logic [SAMPLE_WIDTH-1:0]        quo_low;
   logic signed [SAMPLE_WIDTH-1:0] result_in;

   // The tail of the window is examined while the window rotates, so after
   // a full scan every entry is back in its place.
   assign tail     = window_ff[WINDOW_LENGTH-1];
   assign tail_mag = tail[SAMPLE_WIDTH-1] ? MAG_WIDTH'(-$signed({tail[SAMPLE_WIDTH-1], tail}))
                                          : MAG_WIDTH'({1'b0, tail});
   assign tail_hit = tail_mag > MAG_WIDTH'(dead_band_ff);

   assign sum_mag  = sum_ff[SUM_WIDTH-1] ? SUM_WIDTH'(-sum_ff) : SUM_WIDTH'(sum_ff);

   assign rem_shift = {rem_ff, quo_ff[SUM_WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, count_ff};
   assign rem_ge    = rem_shift >= {1'b0, count_ff};

   assign quo_low   = quo_ff[SAMPLE_WIDTH-1:0];
   assign result_in = (count_ff == '0) ? '0
                    : negative_ff ? $signed(-quo_low) : $signed(quo_low);

   assign status.clear_needed = (req_velocity_sample == '0) || req_motion_lock;
   assign status.scan_last    = (scan_ff == IDX_WIDTH'(WINDOW_LENGTH - 1));
   assign status.count_zero   = (count_ff == '0);
   assign status.div_last     = (step_ff == DIV_WIDTH'(SUM_WIDTH - 1));
   assign status.out_free     = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WINDOW_LENGTH; k++) begin
            window_ff[k] <= '0;
         end
      end else if (cmd.load) begin
         if (status.clear_needed) begin
            for (int k = 0; k < WINDOW_LENGTH; k++) begin
               window_ff[k] <= '0;
            end
         end else begin
            window_ff[0] <= req_velocity_sample;
            for (int k = 1; k < WINDOW_LENGTH; k++) begin
               window_ff[k] <= window_ff[k-1];
            end
         end
      end else if (cmd.accumulate) begin
         window_ff[0] <= window_ff[WINDOW_LENGTH-1];
         for (int k = 1; k < WINDOW_LENGTH; k++) begin
            window_ff[k] <= window_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_band_ff <= DEAD_BAND_RESET;
      end else if (csr_write_enable) begin
         dead_band_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff  <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (cmd.load) begin
         scan_ff  <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (cmd.accumulate) begin
         scan_ff <= scan_ff + 1'b1;
         if (tail_hit) begin
            sum_ff   <= sum_ff + SUM_WIDTH'(tail);
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   // Restoring division of the total's magnitude by the count, one
   // quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.div_start) begin
         step_ff <= '0;
      end else if (cmd.div_step) begin
         step_ff <= step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff      <= sum_mag;
         rem_ff      <= '0;
         negative_ff <= sum_ff[SUM_WIDTH-1];
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[SUM_WIDTH-2:0], rem_ge};
         rem_ff <= rem_ge ? rem_diff[CNT_WIDTH-1:0] : rem_shift[CNT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_filtered_velocity = result_ff;

   // Division only runs with a nonzero divisor.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> count_ff != '0)
      else $error("divide step with zero count");

   // The partial remainder stays below the divisor.
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < count_ff)
      else $error("divider remainder out of range");

   // Writing a result always presents it on the next cycle.
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("result write lost");

endmodule

>>> hdl/speed_feedback_window_average_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed feedback window average core
// Moving average of recent speed samples with a dead band, cleared on a
// zero sample or on motion lock.
// ----------------------------------------------------------------------------
// Sequence: for a normal beat, acceptance is followed by the window scan, the
//   divider setup, the divide steps and the result write. A clearing beat goes
//   straight to the result write; a beat with no qualifying sample skips the
//   divider setup and the divide steps.
// Flow: the core takes a new beat only after the last result write; the window
//   scan takes one entry per cycle and the divider one bit per cycle.
// Reset: synchronous, active high; clears the window and sets the dead band to 5.
// ----------------------------------------------------------------------------
//
// The window is a shift line of 20 samples; a new beat enters at the front.
// To total the qualifying samples the line is rotated once around while the
// tail entry is checked against the dead band, so no indexed read is needed.
// The magnitude of the total is then divided by the count with a restoring
// divider and the sign is put back, which truncates toward zero. A zero
// sample or a motion lock clears the whole window and returns zero; so does
// a window where no sample passes the dead band (with the window kept).
// The output register lets a finished result wait while the next beat is
// already being taken in.
module speed_feedback_window_average_core
   import sfwa_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   // Request channel.
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_velocity_sample,
   input  logic                           req_motion_lock,
   // Response channel.
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_filtered_velocity,
   // Dead band register.
   input  logic                           csr_write_enable,
   input  logic [DEAD_BAND_WIDTH-1:0]     csr_write_data
);

   cmd_type    cmd;
   status_type status;

   // The controller owns sequencing and the request handshake.
   sfwa_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the window, the dead band, the arithmetic and the
   // output register.
   sfwa_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_velocity_sample   (req_velocity_sample),
      .req_motion_lock       (req_motion_lock),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_filtered_velocity (rsp_filtered_velocity)
   );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the speed feedback window average core
// Drives speed beats through the request channel and checks every response
// beat against a predictor of the windowed, dead-banded average. It runs a
// short directed table first, then random beats over several dead band
// settings with varied idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import sfwa_pkg::*;

   // Random beats after the directed table, spread over the dead band phases.
   localparam int RANDOM_BEATS    = 1880;
   localparam int PHASE_COUNT     = 8;
   // Long receiver hold-off, long enough to fill the core and stall its input.
   localparam int HOLD_OFF_CYCLES = 400;
   // Quiet cycles after the last response, a little more than the core latency.
   localparam int DRAIN_CYCLES    = 60;

   // One row of the directed table. When known is set, known_value is the
   // response that can be read straight off the behavior; otherwise the
   // predictor supplies it.
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           lock;
      logic                           known;
      logic signed [SAMPLE_WIDTH-1:0] known_value;
   } beat_row_type;

   localparam int DIRECTED_COUNT = 25;

   // All rows run with the dead band at its reset value of 5.
   localparam beat_row_type DIRECTED_BEATS [DIRECTED_COUNT] = '{
      '{16'sd0,      1'b0, 1'b1, 16'sd0},      // zero sample clears
      '{16'sd100,    1'b1, 1'b1, 16'sd0},      // lock clears
      '{16'sd32767,  1'b0, 1'b1, 16'sd32767},  // lone positive extreme
      '{16'sd0,      1'b0, 1'b1, 16'sd0},
      '{16'sh8000,   1'b0, 1'b1, 16'sh8000},   // lone most negative sample
      '{16'sh8000,   1'b0, 1'b1, 16'sh8000},   // two of them still fit
      '{16'sd5,      1'b0, 1'b0, 16'sd0},      // exactly on the dead band
      '{-16'sd5,     1'b0, 1'b0, 16'sd0},
      '{16'sd6,      1'b0, 1'b0, 16'sd0},      // just past the dead band
      '{16'sd32767,  1'b0, 1'b0, 16'sd0},
      '{16'sh8000,   1'b1, 1'b1, 16'sd0},      // lock with a nonzero sample
      '{16'sd3,      1'b0, 1'b1, 16'sd0},      // nothing qualifies
      '{-16'sd4,     1'b0, 1'b1, 16'sd0},
      '{16'sd7,      1'b0, 1'b1, 16'sd7},      // one qualifying sample
      '{-16'sd8,     1'b0, 1'b0, 16'sd0},      // -1/2 truncates to zero
      '{-16'sd9,     1'b0, 1'b0, 16'sd0},      // -10/3 truncates to -3
      '{16'sd0,      1'b1, 1'b1, 16'sd0},      // zero sample and lock together
      '{16'sd6,      1'b0, 1'b1, 16'sd6},
      '{-16'sd6,     1'b0, 1'b0, 16'sd0},
      '{16'sd32767,  1'b0, 1'b0, 16'sd0},
      '{16'sd32767,  1'b0, 1'b0, 16'sd0},
      '{16'sh8000,   1'b0, 1'b0, 16'sd0},
      '{16'sd1000,   1'b0, 1'b0, 16'sd0},
      '{-16'sd1000,  1'b0, 1'b0, 16'sd0},
      '{16'sd12345,  1'b0, 1'b0, 16'sd0}
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic signed [SAMPLE_WIDTH-1:0] req_velocity_sample = '0;
   logic                           req_motion_lock = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_filtered_velocity;
   logic                           csr_write_enable = 1'b0;
   logic [DEAD_BAND_WIDTH-1:0]     csr_write_data = '0;

   // Predictor state: its own copy of the window and of the dead band.
   logic signed [SAMPLE_WIDTH-1:0] window_model [WINDOW_LENGTH];
   logic [DEAD_BAND_WIDTH-1:0]     dead_band_model = DEAD_BAND_RESET;

   // Filtered velocities still owed by the core, oldest first.
   logic signed [SAMPLE_WIDTH-1:0] expected_velocity_q [$];

   // Idling chances in percent, set by the stimulus process per stretch.
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;

   // The stimulus asks for a long receiver hold-off by bumping the request
   // count; the receiver process serves it and counts the cycles itself.
   int hold_off_requests = 0;
   int hold_off_served   = 0;
   int hold_off_left     = 0;

   int error_count = 0;

   speed_feedback_window_average_core i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_velocity_sample   (req_velocity_sample),
      .req_motion_lock       (req_motion_lock),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_filtered_velocity (rsp_filtered_velocity),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data)
   );

   always #5 clock = ~clock;

   // Shifts one accepted beat into the model window and returns the filtered
   // velocity that the core must produce for it. A zero sample or a lock
   // wipes the whole window, the new entry included. Otherwise only samples
   // whose magnitude is strictly above the dead band take part, and the mean
   // is truncated toward zero, which is what int division does.
   function automatic logic signed [SAMPLE_WIDTH-1:0] window_average(
      input logic signed [SAMPLE_WIDTH-1:0] sample,
      input logic                           lock
   );
      int total;
      int count;
      int value;
      int magnitude;
      total = 0;
      count = 0;
      for (int k = WINDOW_LENGTH - 1; k > 0; k--) begin
         window_model[k] = window_model[k-1];
      end
      window_model[0] = sample;
      if (sample == 0 || lock) begin
         for (int k = 0; k < WINDOW_LENGTH; k++) begin
            window_model[k] = '0;
         end
         return '0;
      end
      for (int k = 0; k < WINDOW_LENGTH; k++) begin
         value = int'(window_model[k]);
         magnitude = (value < 0) ? -value : value;
         if (magnitude > int'(dead_band_model)) begin
            total += value;
            count++;
         end
      end
      // With nothing past the dead band the answer is zero and the window
      // keeps the new sample.
      if (count == 0) begin
         return '0;
      end
      return SAMPLE_WIDTH'(total / count);
   endfunction

   // Random speed sample. Zero is kept rare so that long runs without a
   // clear fill the window and push old samples out of its tail. Many
   // samples sit right around the dead band so the strict comparison is hit
   // from both sides; some are the extremes, the rest span the full range.
   function automatic logic signed [SAMPLE_WIDTH-1:0] random_velocity();
      int pick;
      int magnitude;
      logic [SAMPLE_WIDTH-1:0] raw;
      pick = $urandom_range(99);
      if (pick < 2) begin
         raw = '0;
      end else if (pick < 10) begin
         case ($urandom_range(3))
            0: raw = 16'h7FFF;
            1: raw = 16'h8000;
            2: raw = 16'h0001;
            default: raw = 16'hFFFF;
         endcase
      end else if (pick < 45) begin
         magnitude = int'(dead_band_model) - 2 + int'($urandom_range(4));
         if (magnitude < 1) begin
            magnitude = 1;
         end
         raw = $urandom_range(1) ? SAMPLE_WIDTH'(-magnitude) : SAMPLE_WIDTH'(magnitude);
      end else begin
         raw = SAMPLE_WIDTH'($urandom_range(16'hFFFF));
      end
      return raw;
   endfunction

   // Offers one beat, starting at a falling edge, and returns at the falling
   // edge after it was accepted with the valid still high, so a following
   // beat can go out back to back. A sender gap, if drawn, comes first.
   task automatic send_beat(
      input logic signed [SAMPLE_WIDTH-1:0] sample,
      input logic                           lock,
      input logic                           known,
      input logic signed [SAMPLE_WIDTH-1:0] known_value
   );
      logic signed [SAMPLE_WIDTH-1:0] predicted;
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_velocity_sample <= sample;
      req_motion_lock     <= lock;
      do begin
         @(posedge clock);
      end while (req_stall);
      // The model always advances, even when the response is typed in.
      predicted = window_average(sample, lock);
      expected_velocity_q.push_back(known ? known_value : predicted);
      @(negedge clock);
   endtask

   // Writes the dead band only once the core has handed back every response
   // it owes. Every beat yields a response, so an empty queue means idle.
   // Starts and ends at a falling edge with the request valid already low.
   task automatic write_dead_band(input logic [DEAD_BAND_WIDTH-1:0] value);
      while (expected_velocity_q.size() != 0) begin
         @(negedge clock);
      end
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      dead_band_model = value;
   endtask

   // Receiver: draws a stall every falling edge, or holds off for a long
   // stretch when the stimulus asks for it.
   always @(negedge clock) begin
      if (hold_off_requests != hold_off_served) begin
         hold_off_served <= hold_off_requests;
         hold_off_left   <= HOLD_OFF_CYCLES;
         rsp_stall       <= 1'b1;
      end else if (hold_off_left > 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_stall     <= 1'b1;
      end else begin
         rsp_stall <= (rsp_idle_pct != 0) && ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Response checker: every accepted response beat is matched against the
   // oldest filtered velocity still owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_velocity_q.size() == 0) begin
            $error("filtered_velocity: response beat with nothing expected, got %0d",
                   rsp_filtered_velocity);
            error_count++;
         end else begin
            if (rsp_filtered_velocity !== expected_velocity_q[0]) begin
               $error("filtered_velocity: expected %0d, got %0d",
                      expected_velocity_q[0], rsp_filtered_velocity);
               error_count++;
            end
            void'(expected_velocity_q.pop_front());
         end
      end
   end

   // Stimulus.
   initial begin
      logic [DEAD_BAND_WIDTH-1:0] phase_band [PHASE_COUNT];
      int beats_per_phase;
      int beat_index;
      for (int k = 0; k < WINDOW_LENGTH; k++) begin
         window_model[k] = '0;
      end
      // Dead band settings: both extremes, the reset value, the smallest
      // nonzero band, and a few others.
      phase_band[0] = 8'd0;
      phase_band[1] = 8'd255;
      phase_band[2] = DEAD_BAND_RESET;
      phase_band[3] = 8'd1;
      phase_band[4] = DEAD_BAND_WIDTH'($urandom_range(255));
      phase_band[5] = 8'd128;
      phase_band[6] = 8'd254;
      phase_band[7] = DEAD_BAND_WIDTH'($urandom_range(255));
      beats_per_phase = RANDOM_BEATS / PHASE_COUNT;
      beat_index = 0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table, both sides always ready, dead band at reset value.
      foreach (DIRECTED_BEATS[row]) begin
         send_beat(DIRECTED_BEATS[row].sample, DIRECTED_BEATS[row].lock,
                   DIRECTED_BEATS[row].known, DIRECTED_BEATS[row].known_value);
      end
      req_valid <= 1'b0;

      // Random part. Each phase starts with the sender paused until every
      // owed response has come back, then a new dead band is written. The
      // idling pattern moves with the beat count: sender idles little and
      // receiver a lot, then the reverse, then no idling at all. The last
      // stretch opens with a long receiver hold-off while beats keep coming.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         write_dead_band(phase_band[phase]);
         for (int n = 0; n < beats_per_phase; n++) begin
            if (beat_index < RANDOM_BEATS / 3) begin
               req_idle_pct = 31;
               rsp_idle_pct = 82;
            end else if (beat_index < 2 * RANDOM_BEATS / 3) begin
               req_idle_pct = 82;
               rsp_idle_pct = 31;
            end else begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
            if (beat_index == 2 * RANDOM_BEATS / 3) begin
               hold_off_requests++;
            end
            send_beat(random_velocity(), $urandom_range(99) < 2, 1'b0, '0);
            beat_index++;
         end
         req_valid <= 1'b0;
      end

      while (expected_velocity_q.size() != 0) begin
         @(negedge clock);
      end
      // Any late, unowed response in this window is flagged by the checker.
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog: a normal run needs well under a fifth of this.
   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

>>> filelist.f
hdl/sfwa_pkg.sv
hdl/sfwa_controller.sv
hdl/sfwa_datapath.sv
hdl/speed_feedback_window_average_core.sv
tb/tb_top.sv
